// ===== rtl/srrs_pkg.sv =====
// shared types and constants for the speed readout ramp smoother
package srrs_pkg;

    // default width of the speed fields
    localparam int SPEED_BITS_DEF = 12;

    // working width for the remap, enough for twice the widest speed
    localparam int CALC_W = 18;

    // measured speeds at or above this are stretched as 2*v - knee
    localparam int REMAP_KNEE = 2200;

    typedef enum logic [2:0] {
        RAMP_WAIT     = 3'd0,
        RAMP_RISE     = 3'd1,
        RAMP_FALL     = 3'd2,
        RAMP_SETTLED  = 3'd3,
        RAMP_STOPPING = 3'd4
    } t_ramp_mode;

    localparam logic [1:0] EDIT_SPEED = 2'd1;

    localparam logic [1:0] FORCE_WAIT = 2'd1;
    localparam logic [1:0] FORCE_STOP = 2'd2;

endpackage

// ===== rtl/srrs_ramp.sv =====
// one refresh tick: remap, ramp state step and display value selection
module srrs_ramp #(
    parameter int SPEED_BITS = srrs_pkg::SPEED_BITS_DEF
) (
    input  logic [SPEED_BITS-1:0] i_measured_speed,
    input  logic [SPEED_BITS-1:0] i_target_speed,
    input  logic [SPEED_BITS-1:0] i_set_speed,
    input  logic                  i_running,
    input  logic [1:0]            i_edit_option,
    input  logic [1:0]            i_mode_force,
    input  srrs_pkg::t_ramp_mode  i_mode,
    input  logic [SPEED_BITS:0]   i_prev,
    input  logic [SPEED_BITS:0]   i_disp,
    output srrs_pkg::t_ramp_mode  o_mode,
    output logic [SPEED_BITS:0]   o_prev,
    output logic [SPEED_BITS:0]   o_disp
);
    import srrs_pkg::*;

    localparam int SW = SPEED_BITS + 1;
    localparam logic [CALC_W-1:0] KNEE_X = CALC_W'(REMAP_KNEE);

    logic [CALC_W-1:0] meas_x;
    logic [SW-1:0]     remapped;
    logic [SW-1:0]     tgt_x;
    t_ramp_mode        mode_v;
    logic [SW-1:0]     prev_v;
    logic [SW-1:0]     disp_v;

    // stretch the upper band of the measured speed
    always_comb begin
        meas_x = CALC_W'(i_measured_speed);
        if (meas_x >= KNEE_X) begin
            remapped = SW'((meas_x << 1) - KNEE_X);
        end else begin
            remapped = SW'(i_measured_speed);
        end
    end

    assign tgt_x = SW'(i_target_speed);

    always_comb begin
        mode_v = i_mode;
        prev_v = i_prev;
        disp_v = i_disp;

        // forced mode change comes before anything else in the tick
        if (i_mode_force == FORCE_WAIT) begin
            mode_v = RAMP_WAIT;
        end else if (i_mode_force == FORCE_STOP) begin
            mode_v = RAMP_STOPPING;
        end

        if (!i_running || i_edit_option == EDIT_SPEED) begin
            disp_v = SW'(i_set_speed);
        end else begin
            // wait decides a direction, which is then stepped in this same tick
            if (mode_v == RAMP_WAIT) begin
                if (tgt_x > remapped) begin
                    prev_v = '0;
                    mode_v = RAMP_RISE;
                end else if (tgt_x <= disp_v) begin
                    prev_v = remapped;
                    mode_v = RAMP_FALL;
                end
            end

            case (mode_v)
                RAMP_RISE: begin
                    if (remapped >= tgt_x) begin
                        mode_v = RAMP_SETTLED;
                    end else begin
                        disp_v = (remapped > prev_v) ? remapped : prev_v;
                        prev_v = disp_v;
                    end
                end
                RAMP_FALL: begin
                    if (remapped <= tgt_x) begin
                        mode_v = RAMP_SETTLED;
                    end else begin
                        disp_v = (remapped < prev_v) ? remapped : prev_v;
                        prev_v = disp_v;
                    end
                end
                RAMP_SETTLED: begin
                    disp_v = tgt_x;
                end
                RAMP_STOPPING: begin
                    disp_v = (remapped < prev_v) ? remapped : prev_v;
                    prev_v = disp_v;
                end
                default: begin
                    // still in wait with no direction chosen: hold
                    disp_v = disp_v;
                end
            endcase
        end
    end

    assign o_mode = mode_v;
    assign o_prev = prev_v;
    assign o_disp = disp_v;

endmodule

// ===== rtl/speed_readout_ramp_smoother.sv =====
// speed readout ramp smoother top level: input register, ramp step, result register
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  input     | i_valid / o_ready    | measured, target, set speed, running, edit, force
//  result    | o_valid / i_ready    | o_shown_speed, o_ramp_state
//
// one transaction per cycle sustained while i_ready holds; a result turns valid once its
// input has passed the input register and the ramp step into the result register. the
// ramp step between them is a few compares and a constant remap. synchronous active-low
// reset puts the ramp in wait with zero display. a stalled result holds its register
// and the input register keeps accepting until both are full.
module speed_readout_ramp_smoother #(
    parameter int SPEED_BITS = srrs_pkg::SPEED_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SPEED_BITS-1:0] i_measured_speed,
    input  logic [SPEED_BITS-1:0] i_target_speed,
    input  logic [SPEED_BITS-1:0] i_set_speed,
    input  logic                  i_running,
    input  logic [1:0]            i_edit_option,
    input  logic [1:0]            i_mode_force,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SPEED_BITS:0]   o_shown_speed,
    output logic [2:0]            o_ramp_state
);
    import srrs_pkg::*;

    // input register
    logic                  r_in_valid;
    logic [SPEED_BITS-1:0] r_measured;
    logic [SPEED_BITS-1:0] r_target;
    logic [SPEED_BITS-1:0] r_set;
    logic                  r_running;
    logic [1:0]            r_edit;
    logic [1:0]            r_force;

    // ramp state
    t_ramp_mode            r_mode;
    logic [SPEED_BITS:0]   r_prev;
    logic [SPEED_BITS:0]   r_disp;
    t_ramp_mode            n_mode;
    logic [SPEED_BITS:0]   n_prev;
    logic [SPEED_BITS:0]   n_disp;

    // result register
    logic                  r_out_valid;
    logic [SPEED_BITS:0]   r_out_speed;
    logic [2:0]            r_out_state;

    logic                  advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    srrs_ramp #(
        .SPEED_BITS(SPEED_BITS)
    ) u_ramp (
        .i_measured_speed(r_measured),
        .i_target_speed  (r_target),
        .i_set_speed     (r_set),
        .i_running       (r_running),
        .i_edit_option   (r_edit),
        .i_mode_force    (r_force),
        .i_mode          (r_mode),
        .i_prev          (r_prev),
        .i_disp          (r_disp),
        .o_mode          (n_mode),
        .o_prev          (n_prev),
        .o_disp          (n_disp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= RAMP_WAIT;
            r_prev      <= '0;
            r_disp      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_prev      <= n_prev;
                r_disp      <= n_disp;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_measured <= i_measured_speed;
            r_target   <= i_target_speed;
            r_set      <= i_set_speed;
            r_running  <= i_running;
            r_edit     <= i_edit_option;
            r_force    <= i_mode_force;
        end
        if (advance) begin
            r_out_speed <= n_disp;
            r_out_state <= n_mode;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_shown_speed = r_out_speed;
    assign o_ramp_state  = r_out_state;

endmodule
